// ===== hw/rtl/dcr_pkg.sv =====
// Package for the DC-removal biquad: widths, register indexes, datapath
// command codes and the shared struct types.
// No dependencies; every other file of the block imports it.
package dcr_pkg;

    // Internal word length default and fixed field widths
    localparam int DCR_WORD_LEN = 24;
    localparam int SAMPLE_W     = 16;
    localparam int RESULT_W     = 17;
    localparam int COEF_W       = 24;
    localparam int GAIN_W       = 3;
    localparam int CFG_IDX_W    = 3;
    localparam int CFG_DATA_W   = 24;
    localparam int ACC_W        = 64;

    // Configuration register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_NUM0 = 3'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM1 = 3'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_NUM2 = 3'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN1 = 3'd3;
    localparam logic [CFG_IDX_W-1:0] CFG_DEN2 = 3'd4;
    localparam logic [CFG_IDX_W-1:0] CFG_GAIN = 3'd5;

    // Multiplier operand selection
    typedef logic [2:0] t_mul_sel;
    localparam t_mul_sel MUL_B0 = 3'd0;
    localparam t_mul_sel MUL_B1 = 3'd1;
    localparam t_mul_sel MUL_B2 = 3'd2;
    localparam t_mul_sel MUL_A1 = 3'd3;
    localparam t_mul_sel MUL_A2 = 3'd4;

    // Main accumulator operations
    typedef logic [1:0] t_acc_op;
    localparam t_acc_op ACC_HOLD    = 2'd0;
    localparam t_acc_op ACC_LOAD_D1 = 2'd1;
    localparam t_acc_op ACC_LOAD_D2 = 2'd2;
    localparam t_acc_op ACC_SUB     = 2'd3;

    // Second accumulator operations
    typedef logic [1:0] t_accb_op;
    localparam t_accb_op ACCB_HOLD = 2'd0;
    localparam t_accb_op ACCB_LOAD = 2'd1;
    localparam t_accb_op ACCB_SUB  = 2'd2;

    // Rounding unit source selection
    typedef logic [1:0] t_rnd_sel;
    localparam t_rnd_sel RND_ACC_GAIN = 2'd0;
    localparam t_rnd_sel RND_ACC      = 2'd1;
    localparam t_rnd_sel RND_ACCB     = 2'd2;

    // Configuration register contents
    typedef struct packed {
        logic signed [COEF_W-1:0] num0;
        logic signed [COEF_W-1:0] num1;
        logic signed [COEF_W-1:0] num2;
        logic signed [COEF_W-1:0] den1;
        logic signed [COEF_W-1:0] den2;
        logic [GAIN_W-1:0]        gain;
    } t_cfg;

    // Commands from the controller to the datapath
    typedef struct packed {
        logic     in_load;
        t_mul_sel mul_sel;
        t_acc_op  acc_op;
        t_accb_op accb_op;
        t_rnd_sel rnd_sel;
        logic     wr_r0;
        logic     wr_d1;
        logic     wr_d2;
        logic     out_load;
    } t_dp_cmd;

endpackage

// ===== hw/rtl/dcr_if.sv =====
// Handshake interfaces of the DC-removal biquad: sample input, result output
// and configuration write channel. Depends on dcr_pkg.

// Input sample channel
interface dcr_smp_if import dcr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [SAMPLE_W-1:0] sample_in;
    logic                       restart;

    modport source (output valid, output sample_in, output restart, input ready);
    modport sink   (input valid, input sample_in, input restart, output ready);
endinterface

// Filtered result channel
interface dcr_res_if import dcr_pkg::*; ();
    logic                       valid;
    logic                       ready;
    logic signed [RESULT_W-1:0] filtered_sample;

    modport source (output valid, output filtered_sample, input ready);
    modport sink   (input valid, input filtered_sample, output ready);
endinterface

// Configuration write channel
interface dcr_cfg_if import dcr_pkg::*; ();
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

// ===== hw/rtl/dc_removal_biquad_fixed_unit.sv =====
// DC-removal biquad, second-order fixed-point IIR in transposed direct form
// II. One sample is accepted when the unit is idle and its result is ready
// at the end of the steps; the next sample can be accepted in the cycle the
// result appears, not sooner, as the single shared 24 x WORD_LEN multiplier
// is used five times per sample and the feedback products depend on the
// rounded output node. The result sits in an output register, so a new
// sample is taken while the previous result waits; the unit only stalls at
// the end of a sample if that register is still full. The user must write
// coefficients and the gain shift through the configuration channel only
// while the unit is idle; the unit does not enforce this. Depends on
// dcr_pkg, dcr_if, dcr_cfg_regs, dcr_datapath and dcr_ctrl.
module dc_removal_biquad_fixed_unit import dcr_pkg::*; #(
    parameter int WORD_LEN = DCR_WORD_LEN
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcr_smp_if.sink    i_smp_if,
    dcr_res_if.source  o_res_if,
    dcr_cfg_if.sink    i_cfg_if
);

    t_cfg    cfg;
    t_dp_cmd cmd;
    logic    in_ready;
    logic    out_valid;

    // Configuration registers
    dcr_cfg_regs u_cfg_regs (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cfg_if (i_cfg_if),
        .o_cfg    (cfg)
    );

    // Sequencer
    dcr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_smp_if.valid),
        .o_in_ready  (in_ready),
        .i_out_ready (o_res_if.ready),
        .o_out_valid (out_valid),
        .o_cmd       (cmd)
    );

    // Arithmetic and filter state
    dcr_datapath #(
        .WORD_LEN (WORD_LEN)
    ) u_datapath (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .i_cfg             (cfg),
        .i_sample_in       (i_smp_if.sample_in),
        .i_restart         (i_smp_if.restart),
        .o_filtered_sample (o_res_if.filtered_sample)
    );

    assign i_smp_if.ready = in_ready;
    assign o_res_if.valid = out_valid;

endmodule

// ===== hw/rtl/dcr_cfg_regs.sv =====
// Configuration register file of the DC-removal biquad: coefficients and
// gain shift. Depends on dcr_pkg and dcr_cfg_if.
module dcr_cfg_regs import dcr_pkg::*; (
    input  logic       i_clk,
    input  logic       i_rst_n,
    dcr_cfg_if.sink    i_cfg_if,
    output t_cfg       o_cfg
);

    t_cfg r_cfg;

    // The register file is always ready for a write.
    assign i_cfg_if.ready = 1'b1;
    assign o_cfg          = r_cfg;

    // Register write decode; indexes beyond the list are ignored.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg <= '0;
        end else if (i_cfg_if.valid) begin
            unique case (i_cfg_if.index)
                CFG_NUM0: r_cfg.num0 <= i_cfg_if.data;
                CFG_NUM1: r_cfg.num1 <= i_cfg_if.data;
                CFG_NUM2: r_cfg.num2 <= i_cfg_if.data;
                CFG_DEN1: r_cfg.den1 <= i_cfg_if.data;
                CFG_DEN2: r_cfg.den2 <= i_cfg_if.data;
                CFG_GAIN: r_cfg.gain <= i_cfg_if.data[GAIN_W-1:0];
                default: begin
                end
            endcase
        end
    end

endmodule

// ===== hw/rtl/dcr_datapath.sv =====
// Datapath of the DC-removal biquad: shared multiplier, two 64-bit
// accumulators, round-and-saturate unit and delay registers.
// Depends on dcr_pkg; driven by commands from dcr_ctrl.
module dcr_datapath import dcr_pkg::*; #(
    parameter int WORD_LEN = DCR_WORD_LEN
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  t_dp_cmd                    i_cmd,
    input  t_cfg                       i_cfg,
    input  logic signed [SAMPLE_W-1:0] i_sample_in,
    input  logic                       i_restart,
    output logic signed [RESULT_W-1:0] o_filtered_sample
);

    localparam int XS_SHIFT = WORD_LEN - SAMPLE_W;
    localparam int FRAC     = WORD_LEN - 1;
    localparam int PROD_W   = COEF_W + WORD_LEN;
    localparam int DLY_W    = 2 * WORD_LEN - 1;
    localparam int WIN_HI   = FRAC + WORD_LEN - 1;
    localparam logic signed [WORD_LEN-1:0] WORD_MAX = {1'b0, {(WORD_LEN-1){1'b1}}};
    localparam logic signed [WORD_LEN-1:0] WORD_MIN = {1'b1, {(WORD_LEN-1){1'b0}}};
    localparam logic [ACC_W-1:0]  RND_HALF = ACC_W'(1) << (FRAC - 1);
    localparam logic [WORD_LEN:0] OUT_HALF = (WORD_LEN + 1)'(1) << (XS_SHIFT - 1);

    logic signed [WORD_LEN-1:0] r_xs;
    logic signed [PROD_W-1:0]   r_prod;
    logic [ACC_W-1:0]           r_acc;
    logic [ACC_W-1:0]           n_acc;
    logic [ACC_W-1:0]           r_accb;
    logic [ACC_W-1:0]           n_accb;
    logic signed [WORD_LEN-1:0] r_r0;
    logic signed [WORD_LEN-1:0] r_dly1;
    logic signed [WORD_LEN-1:0] r_dly2;
    logic signed [RESULT_W-1:0] r_y;

    logic signed [COEF_W-1:0]   mul_coef;
    logic signed [WORD_LEN-1:0] mul_opnd;
    logic signed [PROD_W-1:0]   mul_res;
    logic [ACC_W-1:0]           prod_ext;
    logic [ACC_W-1:0]           dly1_ext;
    logic [ACC_W-1:0]           dly2_ext;
    logic [ACC_W-1:0]           rnd_src;
    logic [GAIN_W-1:0]          rnd_shamt;
    logic [ACC_W-1:0]           rnd_in;
    logic [ACC_W-1:0]           rnd_sum;
    logic [ACC_W-1:WIN_HI]      rnd_guard;
    logic                       rnd_ovf;
    logic signed [WORD_LEN-1:0] rnd_word;
    logic [WORD_LEN:0]          y_sum;

    // Shared multiplier: coefficient times widened sample or output node.
    always_comb begin
        unique case (i_cmd.mul_sel)
            MUL_B0: begin
                mul_coef = i_cfg.num0;
                mul_opnd = r_xs;
            end
            MUL_B1: begin
                mul_coef = i_cfg.num1;
                mul_opnd = r_xs;
            end
            MUL_B2: begin
                mul_coef = i_cfg.num2;
                mul_opnd = r_xs;
            end
            MUL_A1: begin
                mul_coef = i_cfg.den1;
                mul_opnd = r_r0;
            end
            MUL_A2: begin
                mul_coef = i_cfg.den2;
                mul_opnd = r_r0;
            end
            default: begin
                mul_coef = i_cfg.num0;
                mul_opnd = r_xs;
            end
        endcase
    end

    assign mul_res = mul_coef * mul_opnd;

    // Operands extended to the accumulator width; delays aligned to the
    // product's fraction point.
    assign prod_ext = {{(ACC_W-PROD_W){r_prod[PROD_W-1]}}, r_prod};
    assign dly1_ext = {{(ACC_W-DLY_W){r_dly1[WORD_LEN-1]}}, r_dly1, {FRAC{1'b0}}};
    assign dly2_ext = {{(ACC_W-DLY_W){r_dly2[WORD_LEN-1]}}, r_dly2, {FRAC{1'b0}}};

    // Accumulator updates; sums wrap at 64 bits.
    always_comb begin
        case (i_cmd.acc_op)
            ACC_LOAD_D1: n_acc = prod_ext + dly1_ext;
            ACC_LOAD_D2: n_acc = prod_ext + dly2_ext;
            ACC_SUB:     n_acc = r_acc - prod_ext;
            default:     n_acc = r_acc;
        endcase
        case (i_cmd.accb_op)
            ACCB_LOAD: n_accb = prod_ext;
            ACCB_SUB:  n_accb = r_accb - prod_ext;
            default:   n_accb = r_accb;
        endcase
    end

    // Round half up to the word's fraction point, then saturate. The gain
    // shift applies to the output node only.
    always_comb begin
        case (i_cmd.rnd_sel)
            RND_ACC_GAIN: begin
                rnd_src   = r_acc;
                rnd_shamt = i_cfg.gain;
            end
            RND_ACCB: begin
                rnd_src   = r_accb;
                rnd_shamt = '0;
            end
            default: begin
                rnd_src   = r_acc;
                rnd_shamt = '0;
            end
        endcase
        rnd_in    = rnd_src << rnd_shamt;
        rnd_sum   = rnd_in + RND_HALF;
        rnd_guard = rnd_sum[ACC_W-1:WIN_HI];
        rnd_ovf   = !((&rnd_guard) || !(|rnd_guard));
        if (rnd_ovf) begin
            rnd_word = rnd_sum[ACC_W-1] ? WORD_MIN : WORD_MAX;
        end else begin
            rnd_word = rnd_sum[WIN_HI:FRAC];
        end
    end

    // Output node rounded back to 16-bit scale; +32768 can occur.
    assign y_sum = {r_r0[WORD_LEN-1], r_r0} + OUT_HALF;

    // Payload registers
    always_ff @(posedge i_clk) begin
        r_prod <= mul_res;
        r_acc  <= n_acc;
        r_accb <= n_accb;
        if (i_cmd.in_load) begin
            r_xs <= {i_sample_in, {XS_SHIFT{1'b0}}};
        end
        if (i_cmd.wr_r0) begin
            r_r0 <= rnd_word;
        end
        if (i_cmd.out_load) begin
            r_y <= y_sum[WORD_LEN:XS_SHIFT];
        end
    end

    // Delay registers: filter state, cleared by reset or a restart flag.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_dly1 <= '0;
            r_dly2 <= '0;
        end else if (i_cmd.in_load && i_restart) begin
            r_dly1 <= '0;
            r_dly2 <= '0;
        end else begin
            if (i_cmd.wr_d1) begin
                r_dly1 <= rnd_word;
            end
            if (i_cmd.wr_d2) begin
                r_dly2 <= rnd_word;
            end
        end
    end

    assign o_filtered_sample = r_y;

endmodule

// ===== hw/rtl/dcr_ctrl.sv =====
// Controller of the DC-removal biquad: sequences the shared multiplier and
// accumulators and owns the result valid flag. Depends on dcr_pkg.
module dcr_ctrl import dcr_pkg::*; (
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_in_valid,
    output logic    o_in_ready,
    input  logic    i_out_ready,
    output logic    o_out_valid,
    output t_dp_cmd o_cmd
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_M0   = 3'd1;
    localparam logic [2:0] ST_A0   = 3'd2;
    localparam logic [2:0] ST_R0   = 3'd3;
    localparam logic [2:0] ST_M1   = 3'd4;
    localparam logic [2:0] ST_A1   = 3'd5;
    localparam logic [2:0] ST_R1   = 3'd6;
    localparam logic [2:0] ST_R2   = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;
    logic       r_out_valid;
    logic       n_out_valid;
    logic       out_free;

    assign o_in_ready  = (r_state == ST_IDLE);
    assign o_out_valid = r_out_valid;
    assign out_free    = !r_out_valid || i_out_ready;

    // Step sequence: b0*x, output node, b1*x and b2*x, then the feedback
    // products a1*y and a2*y, then the two delay nodes.
    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.in_load = i_in_valid;
                if (i_in_valid) begin
                    n_state = ST_M0;
                end
            end
            ST_M0: begin
                o_cmd.mul_sel = MUL_B0;
                n_state       = ST_A0;
            end
            ST_A0: begin
                o_cmd.acc_op  = ACC_LOAD_D1;
                o_cmd.mul_sel = MUL_B1;
                n_state       = ST_R0;
            end
            ST_R0: begin
                o_cmd.rnd_sel = RND_ACC_GAIN;
                o_cmd.wr_r0   = 1'b1;
                o_cmd.acc_op  = ACC_LOAD_D2;
                o_cmd.mul_sel = MUL_B2;
                n_state       = ST_M1;
            end
            ST_M1: begin
                o_cmd.accb_op = ACCB_LOAD;
                o_cmd.mul_sel = MUL_A1;
                n_state       = ST_A1;
            end
            ST_A1: begin
                o_cmd.acc_op  = ACC_SUB;
                o_cmd.mul_sel = MUL_A2;
                n_state       = ST_R1;
            end
            ST_R1: begin
                o_cmd.rnd_sel = RND_ACC;
                o_cmd.wr_d1   = 1'b1;
                o_cmd.accb_op = ACCB_SUB;
                n_state       = ST_R2;
            end
            ST_R2: begin
                o_cmd.rnd_sel = RND_ACCB;
                if (out_free) begin
                    o_cmd.wr_d2    = 1'b1;
                    o_cmd.out_load = 1'b1;
                    n_state        = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Result word flag: set on load, cleared when the word is taken.
    assign n_out_valid = o_cmd.out_load || (r_out_valid && !i_out_ready);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

`ifndef SYNTHESIS
    // A new result never overwrites a word still waiting to be taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.out_load |-> (!r_out_valid || i_out_ready))
        else $error("result word overwritten before it was taken");

    // An accepted word starts the sequence in the next cycle.
    a_start_seq: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in_valid && o_in_ready) |=> (r_state == ST_M0))
        else $error("accepted word did not start the sequence");

    // A result only appears at the end of the sequence.
    a_result_src: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(r_out_valid) |-> ($past(r_state) == ST_R2))
        else $error("result valid rose outside the final step");

    // The delay nodes are written only after the output node is formed.
    a_d1_after_r0: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.wr_d1 |-> ($past(r_state, 3) == ST_R0))
        else $error("delay one written out of order");
`endif

endmodule

// ===== tb/dcr_checker.sv =====
// Scoreboard for the DC-removal biquad. It watches the sample, result and
// configuration channels, predicts each filtered word and compares it.
// Depends on dcr_pkg and the channel interfaces in dcr_if.
module dcr_checker import dcr_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    dcr_smp_if   i_smp_if,
    dcr_res_if   i_res_if,
    dcr_cfg_if   i_cfg_if,
    output int   o_fail_count,
    output int   o_pending,
    output int   o_checked
);

    localparam int WORD      = DCR_WORD_LEN;
    localparam int FRAC      = WORD - 1;
    localparam int OUT_SHIFT = WORD - SAMPLE_W;
    localparam logic signed [ACC_W-1:0] WORD_MAX = (64'sd1 <<< (WORD - 1)) - 64'sd1;
    localparam logic signed [ACC_W-1:0] WORD_MIN = -WORD_MAX - 64'sd1;

    // Shadow copy of the coefficient registers and of the two delay nodes.
    t_cfg                    coefs;
    logic signed [WORD-1:0]  delay_one;
    logic signed [WORD-1:0]  delay_two;

    logic signed [RESULT_W-1:0] expected_q[$];
    logic signed [RESULT_W-1:0] want;
    int fail_count = 0;
    int checked    = 0;

    task automatic report(input string msg);
        $display("ERROR @%0t: %s", $time, msg);
        fail_count++;
    endtask

    // Sign-extend a word-length value into the 64-bit accumulator.
    function automatic logic signed [ACC_W-1:0] widen(input logic [WORD-1:0] v);
        return {{(ACC_W - WORD){v[WORD-1]}}, v};
    endfunction

    // Round half up: add half an LSB, then shift right arithmetically.
    function automatic logic signed [ACC_W-1:0] round_half_up(
        input logic signed [ACC_W-1:0] v,
        input int                      k
    );
        logic signed [ACC_W-1:0] s;
        s = v + (64'sd1 <<< (k - 1));
        return s >>> k;
    endfunction

    function automatic logic signed [ACC_W-1:0] clip_word(input logic signed [ACC_W-1:0] v);
        if (v > WORD_MAX) return WORD_MAX;
        if (v < WORD_MIN) return WORD_MIN;
        return v;
    endfunction

    // One step of the transposed direct form II section. All sums wrap
    // modulo 2^64; only the output node sees the gain shift.
    function automatic logic signed [RESULT_W-1:0] filter_sample(
        input logic signed [SAMPLE_W-1:0] x,
        input logic                       restart
    );
        logic signed [ACC_W-1:0] xs;
        logic signed [ACC_W-1:0] acc;
        logic signed [ACC_W-1:0] out_node;
        logic signed [ACC_W-1:0] node1;
        logic signed [ACC_W-1:0] node2;
        logic signed [ACC_W-1:0] scaled;
        if (restart) begin
            delay_one = '0;
            delay_two = '0;
        end
        xs = {{(ACC_W - SAMPLE_W){x[SAMPLE_W-1]}}, x};
        xs = xs <<< OUT_SHIFT;

        acc = widen(coefs.num0) * xs + (widen(delay_one) <<< FRAC);
        acc = acc << coefs.gain;
        out_node = clip_word(round_half_up(acc, FRAC));
        scaled = round_half_up(out_node, OUT_SHIFT);

        acc = widen(coefs.num1) * xs + (widen(delay_two) <<< FRAC)
            - widen(coefs.den1) * out_node;
        node1 = clip_word(round_half_up(acc, FRAC));

        acc = widen(coefs.num2) * xs - widen(coefs.den2) * out_node;
        node2 = clip_word(round_half_up(acc, FRAC));

        delay_one = node1[WORD-1:0];
        delay_two = node2[WORD-1:0];
        return scaled[RESULT_W-1:0];
    endfunction

    // Results are checked before new samples are predicted: a result can
    // never belong to a sample taken at the same edge.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            coefs     = '0;
            delay_one = '0;
            delay_two = '0;
            expected_q.delete();
        end else begin
            if (i_cfg_if.valid && i_cfg_if.ready) begin
                case (i_cfg_if.index)
                    CFG_NUM0: coefs.num0 = i_cfg_if.data[COEF_W-1:0];
                    CFG_NUM1: coefs.num1 = i_cfg_if.data[COEF_W-1:0];
                    CFG_NUM2: coefs.num2 = i_cfg_if.data[COEF_W-1:0];
                    CFG_DEN1: coefs.den1 = i_cfg_if.data[COEF_W-1:0];
                    CFG_DEN2: coefs.den2 = i_cfg_if.data[COEF_W-1:0];
                    CFG_GAIN: coefs.gain = i_cfg_if.data[GAIN_W-1:0];
                    default: ;
                endcase
            end
            if (i_res_if.valid && i_res_if.ready) begin
                if (expected_q.size() == 0) begin
                    report($sformatf("result word %0d arrived with nothing expected",
                                     i_res_if.filtered_sample));
                end else begin
                    want = expected_q.pop_front();
                    checked++;
                    if (i_res_if.filtered_sample !== want)
                        report($sformatf("filtered_sample is %0d, expected %0d",
                                         i_res_if.filtered_sample, want));
                end
            end
            if (i_smp_if.valid && i_smp_if.ready)
                expected_q.push_back(filter_sample(i_smp_if.sample_in, i_smp_if.restart));
        end
        o_pending    <= expected_q.size();
        o_fail_count <= fail_count;
        o_checked    <= checked;
    end

endmodule

// ===== tb/tb_top.sv =====
// Testbench top for the DC-removal biquad: clock, reset, sample and
// configuration stimulus, random back-pressure on results, and the verdict.
// Depends on dcr_pkg, dcr_if, dc_removal_biquad_fixed_unit and dcr_checker.
module tb_top;
    import dcr_pkg::*;

    // Indexes outside the register map; writes to them must change nothing.
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_LO = 3'd6;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_HI = 3'd7;

    localparam int RAND_PHASES     = 8;
    localparam int ITEMS_PER_PHASE = 110;
    localparam int DRAIN_LIMIT     = 20000;

    typedef enum int {
        SET_DC_BLOCK,
        SET_RANDOM,
        SET_EXTREME,
        SET_MODERATE
    } t_setting;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bit quiet_mode = 1'b0;
    int sent       = 0;
    int restarts   = 0;
    int settings   = 0;

    int fail_count;
    int pending;
    int checked;

    dcr_smp_if smp_if ();
    dcr_res_if res_if ();
    dcr_cfg_if cfg_if ();

    dc_removal_biquad_fixed_unit u_top (
        .i_clk    (clk),
        .i_rst_n  (rst_n),
        .i_smp_if (smp_if),
        .o_res_if (res_if),
        .i_cfg_if (cfg_if)
    );

    dcr_checker u_chk (
        .i_clk        (clk),
        .i_rst_n      (rst_n),
        .i_smp_if     (smp_if),
        .i_res_if     (res_if),
        .i_cfg_if     (cfg_if),
        .o_fail_count (fail_count),
        .o_pending    (pending),
        .o_checked    (checked)
    );

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    // Idle length: mostly none or short, now and then long.
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (quiet_mode || r < 55) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic int signed_range(input int m);
        return int'($urandom_range(0, 2 * m)) - m;
    endfunction

    function automatic int edge_coef();
        case ($urandom_range(0, 4))
            0:       return 8388607;
            1:       return -8388608;
            2:       return 0;
            3:       return 1;
            default: return -1;
        endcase
    endfunction

    // Sample mix: full-range noise, extremes, small values and a DC level.
    function automatic logic signed [SAMPLE_W-1:0] pick_sample(input int dc_level);
        int r;
        r = $urandom_range(0, 99);
        if (r < 50) return SAMPLE_W'($urandom_range(0, 16'hFFFF));
        if (r < 65) begin
            case ($urandom_range(0, 4))
                0:       return 16'sh7FFF;
                1:       return 16'sh8000;
                2:       return 16'sh0000;
                3:       return 16'sh0001;
                default: return 16'shFFFF;
            endcase
        end
        if (r < 80) return SAMPLE_W'(signed_range(256));
        return SAMPLE_W'(dc_level + signed_range(64));
    endfunction

    // Hand one sample word to the block and wait until it is taken.
    task automatic send_sample(input logic signed [SAMPLE_W-1:0] x, input logic restart);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            smp_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        smp_if.valid     <= 1'b1;
        smp_if.sample_in <= x;
        smp_if.restart   <= restart;
        @(posedge clk);
        while (!smp_if.ready) @(posedge clk);
        sent++;
        if (restart) restarts++;
    endtask

    task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_DATA_W-1:0] data);
        int gap;
        gap = idle_len();
        if (gap > 0) begin
            cfg_if.valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        cfg_if.valid <= 1'b1;
        cfg_if.index <= idx;
        cfg_if.data  <= data;
        @(posedge clk);
        while (!cfg_if.ready) @(posedge clk);
    endtask

    // Write every register; the gain word may carry junk above its three bits.
    task automatic program_filter(input int b0, input int b1, input int b2,
                                  input int a1, input int a2,
                                  input logic [CFG_DATA_W-1:0] gain_word);
        write_reg(CFG_NUM0, CFG_DATA_W'(b0));
        write_reg(CFG_NUM1, CFG_DATA_W'(b1));
        write_reg(CFG_NUM2, CFG_DATA_W'(b2));
        write_reg(CFG_DEN1, CFG_DATA_W'(a1));
        write_reg(CFG_DEN2, CFG_DATA_W'(a2));
        write_reg(CFG_GAIN, gain_word);
        if ($urandom_range(0, 1))
            write_reg($urandom_range(0, 1) ? CFG_SPARE_HI : CFG_SPARE_LO,
                      CFG_DATA_W'($urandom_range(0, 24'hFFFFFF)));
        cfg_if.valid <= 1'b0;
        settings++;
    endtask

    // Wait, with a limit, until every expected result has been taken.
    task automatic wait_drained();
        int waited;
        waited = 0;
        smp_if.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0 && waited < DRAIN_LIMIT) begin
            @(posedge clk);
            waited++;
        end
    endtask

    task automatic settle();
        wait_drained();
        repeat (10) @(posedge clk);
    endtask

    function automatic logic [CFG_DATA_W-1:0] gain_word(input int gain);
        logic [CFG_DATA_W-1:0] w;
        w = CFG_DATA_W'($urandom());
        w[GAIN_W-1:0] = GAIN_W'(gain);
        return w;
    endfunction

    // Result side: runs of ready broken by random stalls.
    initial begin : result_drain
        int run;
        int stall;
        res_if.ready = 1'b0;
        while (!rst_n) @(posedge clk);
        forever begin
            res_if.ready <= 1'b1;
            run = quiet_mode ? 50 : $urandom_range(1, 12);
            repeat (run) @(posedge clk);
            stall = idle_len();
            if (stall > 0) begin
                res_if.ready <= 1'b0;
                repeat (stall) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        int       phase;
        int       n;
        int       b0;
        int       gain;
        int       dc_level;
        t_setting style;

        smp_if.valid     = 1'b0;
        smp_if.sample_in = '0;
        smp_if.restart   = 1'b0;
        cfg_if.valid     = 1'b0;
        cfg_if.index     = '0;
        cfg_if.data      = '0;

        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Coefficients straight out of reset are all zero.
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b1);
        settle();

        // Near-unity pass-through of the extremes and the smallest steps.
        program_filter(8388607, 0, 0, 0, 0, gain_word(0));
        send_sample(16'sh7FFF, 1'b0);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sh0001, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        send_sample(16'sh0000, 1'b0);
        settle();

        // Largest gain with extreme feedback: saturated nodes, output at +32768,
        // and a restart on the first sample of the setting.
        program_filter(8388607, -8388608, 8388607, -8388608, 8388607, gain_word(7));
        send_sample(16'sh7FFF, 1'b1);
        send_sample(16'sh8000, 1'b0);
        send_sample(16'sd12345, 1'b0);
        send_sample(16'shFFFF, 1'b0);
        settle();

        // First-order DC blocker with the pole at 0.995, a step and a restart.
        program_filter(8388607, -8388607, 0, -8346665, 0, gain_word(0));
        send_sample(16'sd8000, 1'b1);
        for (n = 0; n < 7; n++) send_sample(16'sd8000, 1'b0);
        send_sample(-16'sd8000, 1'b1);
        send_sample(-16'sd8000, 1'b0);
        send_sample(-16'sd8000, 1'b0);
        settle();

        // Random settings, each followed by a burst of samples.
        for (phase = 0; phase < RAND_PHASES; phase++) begin
            quiet_mode = (phase % 3 == 2);
            gain = (phase == 0) ? 0 : (phase == 1) ? 7 : $urandom_range(0, 7);
            style = t_setting'(phase % 4);
            case (style)
                SET_DC_BLOCK: begin
                    b0 = 8388607 - $urandom_range(0, 400000);
                    program_filter(b0, -b0, 0, -(8388607 - $urandom_range(0, 200000)),
                                   signed_range(1 << 16), gain_word(gain));
                end
                SET_RANDOM: begin
                    program_filter($urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                                   $urandom_range(0, 24'hFFFFFF), $urandom_range(0, 24'hFFFFFF),
                                   $urandom_range(0, 24'hFFFFFF), gain_word(gain));
                end
                SET_EXTREME: begin
                    program_filter(edge_coef(), edge_coef(), edge_coef(), edge_coef(),
                                   edge_coef(), gain_word(gain));
                end
                default: begin
                    program_filter(signed_range(1 << 22), signed_range(1 << 22),
                                   signed_range(1 << 22), signed_range(1 << 22),
                                   signed_range(1 << 21), gain_word(gain));
                end
            endcase
            dc_level = signed_range(20000);
            for (n = 0; n < ITEMS_PER_PHASE; n++)
                send_sample(pick_sample(dc_level), $urandom_range(0, 99) < 4);
            settle();
        end

        quiet_mode = 1'b0;
        wait_drained();
        repeat (20) @(posedge clk);

        $display("Run covered %0d samples (%0d with restart) under %0d coefficient settings.",
                 sent, restarts, settings);
        $display("%0d result words compared, %0d mismatches, %0d still outstanding.",
                 checked, fail_count, pending);
        if (fail_count == 0 && pending == 0) begin
            $display("dc_removal_biquad_fixed_unit test passed");
        end else begin
            $display("dc_removal_biquad_fixed_unit test failed");
        end
        $finish;
    end

    // Hard stop in case a handshake never completes.
    initial begin : watchdog
        #2000000;
        $display("Timeout: the run did not finish in time.");
        $display("dc_removal_biquad_fixed_unit test failed");
        $finish;
    end

endmodule

// ===== files.f =====
hw/rtl/dcr_pkg.sv
hw/rtl/dcr_if.sv
hw/rtl/dcr_cfg_regs.sv
hw/rtl/dcr_datapath.sv
hw/rtl/dcr_ctrl.sv
hw/rtl/dc_removal_biquad_fixed_unit.sv
tb/dcr_checker.sv
tb/tb_top.sv
